// ===== design/msf_pkg.sv =====
package msf_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned CoordW   = 32;
  localparam int unsigned DiffW    = 33;
  localparam int unsigned SumW     = 68;
  localparam int unsigned RootW    = 34;
  localparam int unsigned NumW     = 98;
  localparam int unsigned QuotW    = 65;

  typedef enum logic [0:0] {
    RegSpringStrength = 1'b0,
    RegRestLength     = 1'b1
  } reg_idx_e;

  // Root cell payload: the running root and remainder of the length and
  // of the diagonal rest length, plus what later cells need.
  typedef struct packed {
    logic                 valid;
    logic [SumW-1:0]      len_rem;
    logic [RootW-1:0]     len_root;
    logic [SumW-1:0]      rst_rem;
    logic [RootW-1:0]     rst_root;
    logic                 diag;
    logic [31:0]          rest;
    logic [31:0]          k;
    logic [2:0]           neg;
    logic [DiffW-1:0]     mag_x;
    logic [DiffW-1:0]     mag_y;
    logic [DiffW-1:0]     mag_z;
  } root_t;

  // Divider cell payload: one restoring step on three quotients at once.
  typedef struct packed {
    logic                 valid;
    logic                 live;
    logic [NumW-1:0]      num_x;
    logic [NumW-1:0]      num_y;
    logic [NumW-1:0]      num_z;
    logic [QuotW-1:0]     rem_x;
    logic [QuotW-1:0]     rem_y;
    logic [QuotW-1:0]     rem_z;
    logic [NumW-1:0]      quo_x;
    logic [NumW-1:0]      quo_y;
    logic [NumW-1:0]      quo_z;
    logic [QuotW-1:0]     den;
    logic [2:0]           neg;
  } div_t;

endpackage

// ===== design/msf_root_cell.sv =====
// One bit of a restoring square root for the length and the diagonal rest.
module msf_root_cell #(
  parameter int unsigned Bit = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  msf_pkg::root_t in_i,
  output msf_pkg::root_t out_o
);

  localparam int unsigned SW = msf_pkg::SumW;
  localparam int unsigned RW = msf_pkg::RootW;

  msf_pkg::root_t d;
  logic [SW-1:0] trial_len, trial_rst;

  // test (2*root + 2^bit) * 2^bit against the remainder
  always_comb begin
    d = in_i;
    trial_len = ({{(SW-RW){1'b0}}, in_i.len_root} << (Bit + 1))
              | ({{(SW-1){1'b0}}, 1'b1} << (2 * Bit));
    trial_rst = ({{(SW-RW){1'b0}}, in_i.rst_root} << (Bit + 1))
              | ({{(SW-1){1'b0}}, 1'b1} << (2 * Bit));
    if (in_i.len_rem >= trial_len) begin
      d.len_rem  = in_i.len_rem - trial_len;
      d.len_root = in_i.len_root | (RW'(1) << Bit);
    end
    if (in_i.rst_rem >= trial_rst) begin
      d.rst_rem  = in_i.rst_rem - trial_rst;
      d.rst_root = in_i.rst_root | (RW'(1) << Bit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_o <= '0;
    end else begin
      out_o <= d;
    end
  end

endmodule

// ===== design/msf_div_cell.sv =====
// One quotient bit of a restoring divide, three components in parallel.
module msf_div_cell #(
  parameter int unsigned Bit = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  msf_pkg::div_t in_i,
  output msf_pkg::div_t out_o
);

  localparam int unsigned QW = msf_pkg::QuotW;
  localparam int unsigned NW = msf_pkg::NumW;

  msf_pkg::div_t d;
  logic [QW:0] sx, sy, sz;

  // shift in the next numerator bit, subtract where it fits
  always_comb begin
    d  = in_i;
    sx = {in_i.rem_x, in_i.num_x[Bit]};
    sy = {in_i.rem_y, in_i.num_y[Bit]};
    sz = {in_i.rem_z, in_i.num_z[Bit]};
    d.rem_x = sx[QW-1:0];
    d.rem_y = sy[QW-1:0];
    d.rem_z = sz[QW-1:0];
    if (sx >= {1'b0, in_i.den}) begin
      d.rem_x = QW'(sx - {1'b0, in_i.den});
      d.quo_x = in_i.quo_x | (NW'(1) << Bit);
    end
    if (sy >= {1'b0, in_i.den}) begin
      d.rem_y = QW'(sy - {1'b0, in_i.den});
      d.quo_y = in_i.quo_y | (NW'(1) << Bit);
    end
    if (sz >= {1'b0, in_i.den}) begin
      d.rem_z = QW'(sz - {1'b0, in_i.den});
      d.quo_z = in_i.quo_z | (NW'(1) << Bit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_o <= '0;
    end else begin
      out_o <= d;
    end
  end

endmodule

// ===== design/membrane_spring_force.sv =====
// Harmonic spring force between two membrane nodes. One item may be started
// in every cycle. Each item passes in order through 1 input stage, 2 squaring
// stages, 34 square-root cells, 3 multiply stages, 1 numerator stage, 98
// divider cells and the output register, which applies sign and saturation
// and raises done_o with the result. The cell chains are a 34-bit square
// root and a 98-bit restoring divide, one bit per cell. Results cannot be
// held off. Configuration writes must happen while no item is in flight.
module membrane_spring_force #(
  parameter int unsigned FRAC_BITS = msf_pkg::FracBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic [31:0] first_x_i,
  input  logic [31:0] first_y_i,
  input  logic [31:0] first_z_i,
  input  logic [31:0] second_x_i,
  input  logic [31:0] second_y_i,
  input  logic [31:0] second_z_i,
  input  logic        is_diagonal_i,
  output logic        done_o,
  output logic [31:0] push_x_o,
  output logic [31:0] push_y_o,
  output logic [31:0] push_z_o,
  output logic        applied_o
);

  localparam int unsigned SW = msf_pkg::SumW;
  localparam int unsigned RW = msf_pkg::RootW;
  localparam int unsigned DW = msf_pkg::DiffW;
  localparam int unsigned NW = msf_pkg::NumW;
  localparam int unsigned QW = msf_pkg::QuotW;

  // configuration registers
  logic [31:0] k_q, rest_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= 32'(64'd1 << FRAC_BITS);
      rest_q <= 32'(64'd1 << FRAC_BITS);
    end else if (cfg_we_i) begin
      unique case (msf_pkg::reg_idx_e'(cfg_idx_i))
        msf_pkg::RegSpringStrength: k_q    <= cfg_data_i;
        msf_pkg::RegRestLength:     rest_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 0: differences and magnitudes
  logic [DW-1:0] dx, dy, dz, mx, my, mz;
  assign dx = DW'($signed(first_x_i)) - DW'($signed(second_x_i));
  assign dy = DW'($signed(first_y_i)) - DW'($signed(second_y_i));
  assign dz = DW'($signed(first_z_i)) - DW'($signed(second_z_i));
  assign mx = dx[DW-1] ? DW'(-dx) : dx;
  assign my = dy[DW-1] ? DW'(-dy) : dy;
  assign mz = dz[DW-1] ? DW'(-dz) : dz;

  msf_pkg::root_t s0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q <= '0;
    end else begin
      s0_q.valid    <= start;
      s0_q.len_rem  <= '0;
      s0_q.len_root <= '0;
      s0_q.rst_root <= '0;
      s0_q.rst_rem  <= '0;
      s0_q.diag     <= is_diagonal_i;
      s0_q.rest     <= rest_q;
      s0_q.k        <= k_q;
      s0_q.neg      <= {dz[DW-1], dy[DW-1], dx[DW-1]};
      s0_q.mag_x    <= mx;
      s0_q.mag_y    <= my;
      s0_q.mag_z    <= mz;
    end
  end

  // stage 1: squares summed (one 33x33 multiply per component)
  msf_pkg::root_t s1_q;
  logic [SW-1:0] sqx_q, sqy_q, sqz_q, r2_q;
  msf_pkg::root_t s1a_q;
  always_ff @(posedge clk_i) begin
    sqx_q <= SW'(s0_q.mag_x) * SW'(s0_q.mag_x);
    sqy_q <= SW'(s0_q.mag_y) * SW'(s0_q.mag_y);
    sqz_q <= SW'(s0_q.mag_z) * SW'(s0_q.mag_z);
    r2_q  <= (SW'(s0_q.rest) * SW'(s0_q.rest)) << 1;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1a_q <= '0;
      s1_q  <= '0;
    end else begin
      s1a_q.valid    <= s0_q.valid;
      s1a_q.len_rem  <= '0;
      s1a_q.len_root <= '0;
      s1a_q.rst_rem  <= '0;
      s1a_q.rst_root <= '0;
      s1a_q.diag     <= s0_q.diag;
      s1a_q.rest     <= s0_q.rest;
      s1a_q.k        <= s0_q.k;
      s1a_q.neg      <= s0_q.neg;
      s1a_q.mag_x    <= s0_q.mag_x;
      s1a_q.mag_y    <= s0_q.mag_y;
      s1a_q.mag_z    <= s0_q.mag_z;
      s1_q.valid     <= s1a_q.valid;
      s1_q.len_rem   <= sqx_q + sqy_q + sqz_q;
      s1_q.len_root  <= '0;
      s1_q.rst_rem   <= r2_q;
      s1_q.rst_root  <= '0;
      s1_q.diag      <= s1a_q.diag;
      s1_q.rest      <= s1a_q.rest;
      s1_q.k         <= s1a_q.k;
      s1_q.neg       <= s1a_q.neg;
      s1_q.mag_x     <= s1a_q.mag_x;
      s1_q.mag_y     <= s1a_q.mag_y;
      s1_q.mag_z     <= s1a_q.mag_z;
    end
  end

  // square-root chain, most significant bit first
  msf_pkg::root_t rc [RW+1];
  assign rc[0] = s1_q;
  for (genvar g = 0; g < RW; g++) begin : g_root
    msf_root_cell #(.Bit(RW - 1 - g)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .in_i  (rc[g]),
      .out_o (rc[g + 1])
    );
  end

  // deviation and the numerator k*dev*|d|, multiplies split across stages
  msf_pkg::root_t rt;
  logic [RW-1:0] rest_sel;
  assign rt       = rc[RW];
  assign rest_sel = rt.diag ? rt.rst_root : RW'(rt.rest);

  logic          m0_valid_q, m0_live_q;
  logic [RW-1:0] m0_dev_q, m0_len_q;
  logic [31:0]   m0_k_q;
  logic [2:0]    m0_neg_q;
  logic [DW-1:0] m0_mx_q, m0_my_q, m0_mz_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m0_valid_q <= 1'b0;
    end else begin
      m0_valid_q <= rt.valid;
    end
  end
  always_ff @(posedge clk_i) begin
    m0_live_q <= rt.len_root > rest_sel;
    m0_dev_q  <= rt.len_root - rest_sel;
    m0_len_q  <= rt.len_root;
    m0_k_q    <= rt.k;
    m0_neg_q  <= rt.neg;
    m0_mx_q   <= rt.mag_x;
    m0_my_q   <= rt.mag_y;
    m0_mz_q   <= rt.mag_z;
  end

  // k * dev, split into the low 32 bits and the high 2 bits of dev (<=32x32 each)
  logic          m1_valid_q, m1_live_q;
  logic [65:0]   m1_kd_q;
  logic [RW-1:0] m1_len_q;
  logic [2:0]    m1_neg_q;
  logic [DW-1:0] m1_mx_q, m1_my_q, m1_mz_q;
  logic [63:0]   kd_lo;
  logic [33:0]   kd_hi;
  assign kd_lo = 64'(m0_k_q) * 64'(m0_dev_q[31:0]);
  assign kd_hi = 34'(m0_k_q) * 34'(m0_dev_q[RW-1:32]);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_valid_q <= 1'b0;
    end else begin
      m1_valid_q <= m0_valid_q;
    end
  end
  always_ff @(posedge clk_i) begin
    m1_live_q <= m0_live_q;
    m1_kd_q   <= 66'(kd_lo) + (66'(kd_hi) << 32);
    m1_len_q  <= m0_len_q;
    m1_neg_q  <= m0_neg_q;
    m1_mx_q   <= m0_mx_q;
    m1_my_q   <= m0_my_q;
    m1_mz_q   <= m0_mz_q;
  end

  // (k*dev) * |d| as partial products on 33-bit slices of k*dev
  logic          m2_valid_q, m2_live_q;
  logic [RW-1:0] m2_len_q;
  logic [2:0]    m2_neg_q;
  logic [65:0]   px_lo_q, py_lo_q, pz_lo_q, px_hi_q, py_hi_q, pz_hi_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_valid_q <= 1'b0;
    end else begin
      m2_valid_q <= m1_valid_q;
    end
  end
  always_ff @(posedge clk_i) begin
    m2_live_q <= m1_live_q;
    m2_len_q  <= m1_len_q;
    m2_neg_q  <= m1_neg_q;
    px_lo_q   <= 66'(m1_kd_q[32:0]) * 66'(m1_mx_q);
    py_lo_q   <= 66'(m1_kd_q[32:0]) * 66'(m1_my_q);
    pz_lo_q   <= 66'(m1_kd_q[32:0]) * 66'(m1_mz_q);
    px_hi_q   <= 66'(m1_kd_q[65:33]) * 66'(m1_mx_q);
    py_hi_q   <= 66'(m1_kd_q[65:33]) * 66'(m1_my_q);
    pz_hi_q   <= 66'(m1_kd_q[65:33]) * 66'(m1_mz_q);
  end

  msf_pkg::div_t dc [NW+1];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc[0] <= '0;
    end else begin
      dc[0].valid <= m2_valid_q;
      dc[0].live  <= m2_live_q;
      dc[0].num_x <= NW'(px_lo_q) + (NW'(px_hi_q) << 33);
      dc[0].num_y <= NW'(py_lo_q) + (NW'(py_hi_q) << 33);
      dc[0].num_z <= NW'(pz_lo_q) + (NW'(pz_hi_q) << 33);
      dc[0].rem_x <= '0;
      dc[0].rem_y <= '0;
      dc[0].rem_z <= '0;
      dc[0].quo_x <= '0;
      dc[0].quo_y <= '0;
      dc[0].quo_z <= '0;
      dc[0].den   <= QW'(m2_len_q) << FRAC_BITS;
      dc[0].neg   <= m2_neg_q;
    end
  end

  // divider chain, most significant numerator bit first
  for (genvar g = 0; g < NW; g++) begin : g_div
    msf_div_cell #(.Bit(NW - 1 - g)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .in_i  (dc[g]),
      .out_o (dc[g + 1])
    );
  end

  // sign and saturation
  function automatic logic [31:0] sat(input logic [NW-1:0] q, input logic neg);
    logic [31:0] r;
    if (neg) begin
      if (q >= NW'(32'h8000_0000)) r = 32'h8000_0000;
      else                         r = 32'(-q[31:0]);
    end else begin
      if (q > NW'(32'h7FFF_FFFF))  r = 32'h7FFF_FFFF;
      else                         r = q[31:0];
    end
    return r;
  endfunction

  msf_pkg::div_t dq;
  logic [31:0] fx, fy, fz;
  assign dq = dc[NW];
  assign fx = dq.live ? sat(dq.quo_x, dq.neg[0]) : '0;
  assign fy = dq.live ? sat(dq.quo_y, dq.neg[1]) : '0;
  assign fz = dq.live ? sat(dq.quo_z, dq.neg[2]) : '0;

  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dq.valid;
    end
  end
  always_ff @(posedge clk_i) begin
    push_x_o  <= fx;
    push_y_o  <= fy;
    push_z_o  <= fz;
    applied_o <= (fx != '0) || (fy != '0) || (fz != '0);
  end
  assign done_o = done_q;

  // a skipped spring never reports a force
  a_skip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dq.valid && !dq.live |=> !applied_o)
    else $error("force applied on unstretched spring");

  // applied matches nonzero push
  a_applied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (applied_o == ((push_x_o != '0) || (push_y_o != '0) || (push_z_o != '0))))
    else $error("applied flag disagrees with push");

  // every item entering the divider chain has left the root chain before
  a_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dc[0].valid |-> $past(rc[RW].valid, 4))
    else $error("item lost between root and divider");

endmodule
